// ----- sv/amp_pkg.sv -----
// Package for the audio mip pyramid builder: sizes, the chain record type
// and the result sequencer's phase type. Depends on nothing.
`default_nettype none

package amp_pkg;

  localparam int BUFFER_SIZE = 1024;
  localparam int LEVELS      = 11;
  localparam int FRAC_BITS   = 14;
  localparam int MAX_RESULTS = 33;

  localparam int CNT_W  = $clog2(BUFFER_SIZE);
  localparam int LVL_W  = 4;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 15;
  localparam int SMP_W  = 16;
  localparam int EMIT_W = $clog2(MAX_RESULTS + 1);

  localparam logic [VAL_W-1:0] ONE = VAL_W'(1 << FRAC_BITS);

  typedef logic [VAL_W-1:0] val_t;

  // One item as it travels along the row of level cells.
  typedef struct packed {
    logic                   valid;
    logic                   alive;
    logic [CNT_W-1:0]       idx;
    logic [LVL_W-1:0]       top;
    val_t                   cur;
    val_t [LEVELS-1:0]      vals;
  } rec_t;

  typedef enum logic [2:0] {
    PH_LEAD0,
    PH_LEAD1,
    PH_ENTRY,
    PH_TRAIL0,
    PH_TRAIL1
  } phase_e;

endpackage

`default_nettype wire

// ----- sv/amp_if.sv -----
// Channel interfaces of the audio mip pyramid builder: sample input and
// result output. Depends on amp_pkg.
`default_nettype none

interface amp_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [amp_pkg::SMP_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface amp_out_if;
  logic                       valid;
  logic                       ready;
  logic [amp_pkg::LVL_W-1:0]  level;
  logic [amp_pkg::POS_W-1:0]  position;
  logic [amp_pkg::VAL_W-1:0]  value;
  logic                       frame_end;
  logic                       last;

  modport source (output valid, output level, output position, output value,
                  output frame_end, output last, input ready);
  modport sink   (input valid, input level, input position, input value,
                  input frame_end, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/amp_cell.sv -----
// One level cell of the pyramid row: keeps the pending pair value of its
// level and forms the average for the next cell. Depends on amp_pkg.
`default_nettype none

module amp_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          en_i,
  input  wire  [amp_pkg::LVL_W-1:0]    lvl_i,
  input  wire  amp_pkg::rec_t          rec_i,
  output amp_pkg::rec_t                rec_o
);

  amp_pkg::rec_t                rec_q, rec_d;
  amp_pkg::val_t                pend_q;
  logic                         pend_we;
  logic [amp_pkg::CNT_W-1:0]    idx_l;
  logic [amp_pkg::CNT_W-1:0]    hi_idx;
  logic [amp_pkg::CNT_W:0]      hi_cnt;
  logic [amp_pkg::VAL_W:0]      sum;

  always_comb begin
    idx_l  = rec_i.idx >> lvl_i;
    hi_idx = idx_l >> 1;
    hi_cnt = (($bits(hi_cnt))'(amp_pkg::BUFFER_SIZE) >> lvl_i) >> 1;
    sum    = {1'b0, pend_q} + {1'b0, rec_i.cur};
  end

  always_comb begin
    rec_d   = rec_i;
    pend_we = 1'b0;
    if (rec_i.valid && rec_i.alive) begin
      rec_d.vals[lvl_i] = rec_i.cur;
      rec_d.top         = lvl_i;
      if (lvl_i == amp_pkg::LVL_W'(amp_pkg::LEVELS - 1)) begin
        rec_d.alive = 1'b0;
      end else if (!idx_l[0]) begin
        pend_we     = 1'b1;
        rec_d.alive = 1'b0;
      end else if ({1'b0, hi_idx} >= hi_cnt) begin
        rec_d.alive = 1'b0;
      end else begin
        rec_d.cur = sum[amp_pkg::VAL_W:1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (en_i) begin
      rec_q <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && pend_we) begin
      pend_q <= rec_i.cur;
    end
  end

  assign rec_o = rec_q;

endmodule

`default_nettype wire

// ----- sv/amp_ser.sv -----
// Result sequencer at the end of the cell row: walks the borders and
// entries of every level that one item reached, one result per cycle while
// the receiver is ready. Depends on amp_pkg and amp_if.
`default_nettype none

module amp_ser (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire  amp_pkg::rec_t  rec_i,
  output logic           take_o,
  amp_out_if.source      res_o
);

  amp_pkg::rec_t                 rec_q, rec_d;
  logic                          busy_q, busy_d;
  logic [amp_pkg::LVL_W-1:0]     lv_q, lv_d;
  amp_pkg::phase_e               ph_q, ph_d;
  logic [amp_pkg::EMIT_W-1:0]    emit_q, emit_d;

  logic [amp_pkg::CNT_W-1:0]     idx_l;
  logic [amp_pkg::CNT_W-1:0]     low_mask;
  logic [amp_pkg::POS_W-1:0]     cnt_l;
  logic                          last_ent;
  logic                          next_first;
  logic                          is_last;
  amp_pkg::phase_e               adv_ph;
  logic [amp_pkg::LVL_W-1:0]     adv_lv;

  always_comb begin
    idx_l      = rec_q.idx >> lv_q;
    low_mask   = ~({amp_pkg::CNT_W{1'b1}} << lv_q);
    cnt_l      = amp_pkg::POS_W'(amp_pkg::BUFFER_SIZE) >> lv_q;
    last_ent   = &(rec_q.idx | low_mask);
    next_first = (idx_l >> 1) == '0;
  end

  // Output decode.
  always_comb begin
    is_last = (emit_q == amp_pkg::EMIT_W'(amp_pkg::MAX_RESULTS - 1)) ||
              (lv_q == rec_q.top &&
               ((ph_q == amp_pkg::PH_ENTRY && !last_ent) || ph_q == amp_pkg::PH_TRAIL1));
    res_o.valid    = busy_q;
    res_o.level    = lv_q;
    res_o.value    = rec_q.vals[lv_q];
    res_o.last     = is_last;
    res_o.frame_end = is_last &&
                      (rec_q.idx == amp_pkg::CNT_W'(amp_pkg::BUFFER_SIZE - 1));
    case (ph_q)
      amp_pkg::PH_LEAD0:  res_o.position = '0;
      amp_pkg::PH_LEAD1:  res_o.position = amp_pkg::POS_W'(1);
      amp_pkg::PH_ENTRY:  res_o.position = amp_pkg::POS_W'(idx_l) + amp_pkg::POS_W'(2);
      amp_pkg::PH_TRAIL0: res_o.position = cnt_l + amp_pkg::POS_W'(2);
      amp_pkg::PH_TRAIL1: res_o.position = cnt_l + amp_pkg::POS_W'(3);
      default:            res_o.position = '0;
    endcase
    take_o = !busy_q || (res_o.ready && is_last);
  end

  // Next state.
  always_comb begin
    adv_lv = lv_q;
    case (ph_q)
      amp_pkg::PH_LEAD0:  adv_ph = amp_pkg::PH_LEAD1;
      amp_pkg::PH_LEAD1:  adv_ph = amp_pkg::PH_ENTRY;
      amp_pkg::PH_ENTRY: begin
        if (last_ent) begin
          adv_ph = amp_pkg::PH_TRAIL0;
        end else begin
          adv_lv = lv_q + amp_pkg::LVL_W'(1);
          adv_ph = next_first ? amp_pkg::PH_LEAD0 : amp_pkg::PH_ENTRY;
        end
      end
      amp_pkg::PH_TRAIL0: adv_ph = amp_pkg::PH_TRAIL1;
      amp_pkg::PH_TRAIL1: begin
        adv_lv = lv_q + amp_pkg::LVL_W'(1);
        adv_ph = next_first ? amp_pkg::PH_LEAD0 : amp_pkg::PH_ENTRY;
      end
      default:            adv_ph = amp_pkg::PH_ENTRY;
    endcase

    busy_d = busy_q;
    rec_d  = rec_q;
    lv_d   = lv_q;
    ph_d   = ph_q;
    emit_d = emit_q;
    if (take_o) begin
      busy_d = rec_i.valid;
      if (rec_i.valid) begin
        rec_d  = rec_i;
        lv_d   = '0;
        ph_d   = (rec_i.idx == '0) ? amp_pkg::PH_LEAD0 : amp_pkg::PH_ENTRY;
        emit_d = '0;
      end
    end else if (res_o.ready) begin
      lv_d   = adv_lv;
      ph_d   = adv_ph;
      emit_d = emit_q + amp_pkg::EMIT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lv_q   <= '0;
      ph_q   <= amp_pkg::PH_ENTRY;
      emit_q <= '0;
    end else begin
      busy_q <= busy_d;
      lv_q   <= lv_d;
      ph_q   <= ph_d;
      emit_q <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

`default_nettype wire

// ----- sv/audio_mip_pyramid_builder.sv -----
// Top level of the audio mip pyramid builder: input counter and clamp, a row
// of level cells and the result sequencer. Depends on amp_pkg, amp_if,
// amp_cell and amp_ser.
// The record of a sample passes the register of every level cell and then
// the sequencer's register before its first result appears.
// Throughput: one result per cycle while the receiver is ready; a sample
// has from 1 to 33 results, about 2 on average.
// Reset clears the frame counter and all valid flags; pending pair values
// stay unknown until written.
`default_nettype none

module audio_mip_pyramid_builder (
  input  wire        clk_i,
  input  wire        rst_ni,
  amp_in_if.sink     smp_i,
  amp_out_if.source  res_o
);

  amp_pkg::rec_t               recs [amp_pkg::LEVELS+1];
  logic [amp_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                        en;
  logic                        take;
  logic                        in_xfer;
  amp_pkg::val_t               clamped;

  assign en          = !recs[amp_pkg::LEVELS].valid || take;
  assign smp_i.ready = en;
  assign in_xfer     = smp_i.valid && en;

  always_comb begin
    if (smp_i.sample < 0) begin
      clamped = '0;
    end else if (smp_i.sample > $signed({1'b0, amp_pkg::ONE})) begin
      clamped = amp_pkg::ONE;
    end else begin
      clamped = smp_i.sample[amp_pkg::VAL_W-1:0];
    end

    recs[0]       = '0;
    recs[0].valid = in_xfer;
    recs[0].alive = 1'b1;
    recs[0].idx   = cnt_q;
    recs[0].cur   = clamped;

    cnt_d = (cnt_q == amp_pkg::CNT_W'(amp_pkg::BUFFER_SIZE - 1)) ? '0
          : cnt_q + amp_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_xfer) begin
      cnt_q <= cnt_d;
    end
  end

  for (genvar g = 0; g < amp_pkg::LEVELS; g++) begin : g_cell
    amp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .lvl_i  (amp_pkg::LVL_W'(g)),
      .rec_i  (recs[g]),
      .rec_o  (recs[g+1])
    );
  end

  amp_ser u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (recs[amp_pkg::LEVELS]),
    .take_o (take),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

// ----- sv/amp_chk.sv -----
// Port checker for the audio mip pyramid builder and its bind to the top
// level. Depends on amp_pkg and audio_mip_pyramid_builder.
`default_nettype none

module amp_chk (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         out_valid_i,
  input  wire                         out_ready_i,
  input  wire  [amp_pkg::LVL_W-1:0]   level_i,
  input  wire  [amp_pkg::POS_W-1:0]   position_i,
  input  wire  [amp_pkg::VAL_W-1:0]   value_i,
  input  wire                         frame_end_i,
  input  wire                         last_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(level_i) &&
    $stable(position_i) && $stable(value_i) && $stable(last_i))
    else $error("result changed while stalled");

  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> last_i)
    else $error("frame end on a result that is not the last one");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> value_i <= amp_pkg::ONE &&
    level_i <= amp_pkg::LVL_W'(amp_pkg::LEVELS - 1))
    else $error("result value or level out of range");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=> out_valid_i)
    else $error("results of one sample were interrupted");

endmodule

bind audio_mip_pyramid_builder amp_chk u_amp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .level_i     (res_o.level),
  .position_i  (res_o.position),
  .value_i     (res_o.value),
  .frame_end_i (res_o.frame_end),
  .last_i      (res_o.last)
);

`default_nettype wire

// ----- dv/amp_checker.sv -----
// Scoreboard for the audio mip pyramid builder: watches the sample and result
// channels, predicts every pyramid result and compares it field by field.
// Depends on amp_pkg and amp_if.
`timescale 1ns / 100ps

module amp_checker
  import amp_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  amp_in_if    smp_i,
  amp_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] position;
    val_t             value;
    logic             frame_end;
    logic             last;
  } pyr_result_t;

  pyr_result_t expected_results[$];
  pyr_result_t sample_results[$];

  int   frame_pos = 0;
  val_t pair_first [LEVELS];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report(input string what);
    if (fail_count_o < 30) $display("%0t ns: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  function automatic void emit_slot(input int lvl, input int pos, input val_t v);
    pyr_result_t r;
    r.level     = LVL_W'(lvl);
    r.position  = POS_W'(pos);
    r.value     = v;
    r.frame_end = 1'b0;
    r.last      = 1'b0;
    sample_results.push_back(r);
  endfunction

  // Works out every result caused by one sample and queues them in order.
  task automatic predict_pyramid(input logic signed [SMP_W-1:0] s);
    int          raw;
    int          idx;
    int          cnt;
    int          lvl;
    int          start_pos;
    val_t        v;
    pyr_result_t r;
    raw = s;
    if (raw < 0) v = '0;
    else if (raw > int'(ONE)) v = ONE;
    else v = val_t'(raw);
    start_pos = (frame_pos >= BUFFER_SIZE) ? 0 : frame_pos;
    idx = start_pos;
    cnt = BUFFER_SIZE;
    lvl = 0;
    sample_results.delete();
    forever begin
      if (idx == 0) begin
        emit_slot(lvl, 0, v);
        emit_slot(lvl, 1, v);
      end
      emit_slot(lvl, idx + 2, v);
      if (idx + 1 == cnt) begin
        emit_slot(lvl, cnt + 2, v);
        emit_slot(lvl, cnt + 3, v);
      end
      if (lvl + 1 >= LEVELS || lvl + 1 > (1 << LVL_W) - 1) break;
      if (idx % 2 == 0) begin
        pair_first[lvl] = v;
        break;
      end
      if ((idx >> 1) >= (cnt >> 1)) break;
      v = val_t'((int'(pair_first[lvl]) + int'(v)) >> 1);
      idx = idx >> 1;
      cnt = cnt >> 1;
      lvl++;
    end
    while (sample_results.size() > MAX_RESULTS) void'(sample_results.pop_back());
    r = sample_results.pop_back();
    r.last = 1'b1;
    if (start_pos == BUFFER_SIZE - 1) r.frame_end = 1'b1;
    sample_results.push_back(r);
    foreach (sample_results[i]) expected_results.push_back(sample_results[i]);
    frame_pos = (start_pos + 1 >= BUFFER_SIZE) ? 0 : start_pos + 1;
  endtask

  always @(posedge clk_i) begin : watch
    pyr_result_t got;
    pyr_result_t want;
    if (rst_ni) begin
      if (smp_i.valid && smp_i.ready) predict_pyramid(smp_i.sample);
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.level, res_i.position, res_i.value, res_i.frame_end, res_i.last};
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result level %0d position %0d value %0d",
                           got.level, got.position, got.value));
        end else begin
          want = expected_results.pop_front();
          check_field("level", got.level, want.level);
          check_field("position", got.position, want.position);
          check_field("value", got.value, want.value);
          check_field("frame_end", got.frame_end, want.frame_end);
          check_field("last", got.last, want.last);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the audio mip pyramid builder: clock, reset, sample
// stimulus, result back-pressure and the verdict. Depends on amp_pkg, amp_if,
// amp_checker and the block itself.
`timescale 1ns / 100ps

module tb;
  import amp_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   results_pending;
  int   samples_sent = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  bit   hold_off_req = 1'b0;

  int corner_values[$] = '{-32768, -1, 0, 1, 16383, 16384, 16385, 32767,
                           16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384,
                           1, 0, 3, 0, 16383, 16384, 0, 32767};

  amp_in_if  smp_ch ();
  amp_out_if res_ch ();

  audio_mip_pyramid_builder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .smp_i  (smp_ch),
    .res_o  (res_ch)
  );

  amp_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .smp_i        (smp_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic int next_gap();
    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
    return tx_calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic signed [SMP_W-1:0] draw_sample();
    case ($urandom_range(0, 5))
      0, 1:    draw_sample = SMP_W'($urandom);
      2:       draw_sample = SMP_W'($urandom_range(int'(ONE) - 8, int'(ONE) + 8));
      3:       draw_sample = SMP_W'($urandom_range(0, 8));
      default: draw_sample = SMP_W'($urandom_range(0, int'(ONE)));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic put_sample(input logic signed [SMP_W-1:0] s, input int gap);
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    smp_ch.valid  <= 1'b1;
    smp_ch.sample <= s;
    do @(posedge clk); while (!(smp_ch.valid && smp_ch.ready));
    samples_sent++;
    @(negedge clk);
  endtask

  // Stops offering samples and waits until every expected result has come.
  task automatic wait_drained();
    smp_ch.valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
  endtask

  initial begin
    smp_ch.valid  = 1'b0;
    smp_ch.sample = '0;
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (corner_values[i]) put_sample(SMP_W'(corner_values[i]), next_gap());
    wait_drained();

    repeat (60) put_sample(draw_sample(), next_gap());

    // The receiver stalls for a long stretch while samples keep coming.
    hold_off_req = 1'b1;
    repeat (40) put_sample(draw_sample(), 0);
    wait_drained();

    // Finish with randomly spaced samples.
    while (samples_sent < 160) put_sample(draw_sample(), next_gap());

    wait_drained();
    repeat (50) @(negedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        gap = 400;
        hold_off_req = 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        gap = rx_calm ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      @(negedge clk);
    end
  end

endmodule
